### design/mfd_pkg.sv
package mfd_pkg;

  localparam int MAX_FRAME   = 64;
  localparam int MIN_FRAME   = 15;
  localparam int FIELD_COUNT = 13;
  localparam int FIELD_BASE  = 2;
  localparam int CNT_W       = $clog2(MAX_FRAME + 1);
  localparam int OUT_W       = 104;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  HDR_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_BAD_HDR = 2'd2,
    ST_CRC_ERR = 2'd3
  } status_t;

  // Packed so that status lands in the lowest bits
  typedef struct packed {
    logic [7:0]         voltage;
    logic [7:0]         temperature;
    logic signed [15:0] current;
    logic signed [15:0] velocity;
    logic signed [31:0] position;
    logic [7:0]         motor_state;
    logic [7:0]         node_id;
    status_t            status;
  } result_t;

  localparam int RES_W = $bits(result_t);

  // One byte of reflected CRC-16, LSB first
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### design/mfd_frame_state.sv
module mfd_frame_state
  import mfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  logic       frame_end,
  output logic       res_valid,
  output result_t    res
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [15:0]      lag0_r, lag0_nxt;
  logic [15:0]      lag1_r, lag1_nxt;
  logic [7:0]       prev0_r, prev0_nxt;
  logic [7:0]       prev1_r, prev1_nxt;
  logic             hdr_ok_r, hdr_ok_nxt;
  logic [7:0]       field_r [FIELD_COUNT];
  logic [7:0]       field_now [FIELD_COUNT];
  logic             store;
  status_t          status;

  assign store = count_r < CNT_W'(MAX_FRAME);

  always_comb begin
    count_nxt  = count_r;
    crc_nxt    = crc_r;
    lag0_nxt   = lag0_r;
    lag1_nxt   = lag1_r;
    prev0_nxt  = prev0_r;
    prev1_nxt  = prev1_r;
    hdr_ok_nxt = hdr_ok_r;
    if (store) begin
      count_nxt = count_r + 1'b1;
      crc_nxt   = crc_step(crc_r, rx_byte);
      lag0_nxt  = crc_r;
      lag1_nxt  = lag0_r;
      prev0_nxt = rx_byte;
      prev1_nxt = prev0_r;
      if (count_r < CNT_W'(FIELD_BASE) && rx_byte != HDR_BYTE) begin
        hdr_ok_nxt = 1'b0;
      end
    end
  end

  // Fields as they stand after this byte, the byte itself included
  always_comb begin
    for (int k = 0; k < FIELD_COUNT; k++) begin
      field_now[k] = (store && count_r == CNT_W'(k + FIELD_BASE)) ? rx_byte : field_r[k];
    end
  end

  // Judge the frame on the state as it stands after this byte
  always_comb begin
    if (count_nxt < CNT_W'(MIN_FRAME)) begin
      status = ST_SHORT;
    end else if (!hdr_ok_nxt) begin
      status = ST_BAD_HDR;
    end else if (lag1_nxt != {prev0_nxt, prev1_nxt}) begin
      status = ST_CRC_ERR;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res        = '0;
    res.status = status;
    if (status == ST_OK) begin
      res.node_id     = field_now[0];
      res.motor_state = field_now[1];
      res.position    = {field_now[6], field_now[5], field_now[4], field_now[3]};
      res.velocity    = {field_now[8], field_now[7]};
      res.current     = {field_now[10], field_now[9]};
      res.temperature = field_now[11];
      res.voltage     = field_now[12];
    end
  end

  assign res_valid = step && frame_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      crc_r    <= CRC_INIT;
      lag0_r   <= CRC_INIT;
      lag1_r   <= CRC_INIT;
      prev0_r  <= '0;
      prev1_r  <= '0;
      hdr_ok_r <= 1'b1;
    end else if (step) begin
      if (frame_end) begin
        count_r  <= '0;
        crc_r    <= CRC_INIT;
        lag0_r   <= CRC_INIT;
        lag1_r   <= CRC_INIT;
        prev0_r  <= '0;
        prev1_r  <= '0;
        hdr_ok_r <= 1'b1;
      end else begin
        count_r  <= count_nxt;
        crc_r    <= crc_nxt;
        lag0_r   <= lag0_nxt;
        lag1_r   <= lag1_nxt;
        prev0_r  <= prev0_nxt;
        prev1_r  <= prev1_nxt;
        hdr_ok_r <= hdr_ok_nxt;
      end
    end
  end

  // Field bytes are only reported for full frames, so they need no clearing
  always_ff @(posedge clk) begin
    for (int k = 0; k < FIELD_COUNT; k++) begin
      if (step && store && count_r == CNT_W'(k + FIELD_BASE)) begin
        field_r[k] <= rx_byte;
      end
    end
  end

endmodule

### design/motor_feedback_frame_decoder.sv
// Motor feedback frame decoder.
// Input stream: one frame byte per item on in_tdata, in_tlast on the frame's
// last byte. Output stream: one item per frame, issued for the last byte,
// carrying a status code (ok, too short, bad 0xFF 0xFF header, CRC mismatch)
// and the decoded motor fields; fields read zero unless the status is ok.
// The CRC is Modbus CRC-16 over all but the two trailer bytes, which hold
// the expected value little-endian. Bytes beyond MAX_FRAME are dropped.
// Throughput: one byte per cycle while the receiver does not stall the output.
// The CRC byte step is combinational, between the input register and the
// result register. A last byte goes through the input register, then the
// result register, before out_tvalid rises for its frame.
// Reset (rst_n low, synchronous): both registers empty, frame state cleared.
// The frame state also returns to its reset state after every last byte.
// When the receiver stalls, the result holds in the output register and the
// input register can still take one more byte if it is empty; after that
// in_tready drops until out_tready frees the output.
module motor_feedback_frame_decoder
  import mfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] rx_byte
  input  logic             in_tlast,   // frame_end
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // [1:0] status, [9:2] node id,
                                       // [17:10] motor_state, [49:18] position,
                                       // [65:50] velocity, [81:66] current,
                                       // [89:82] temperature, [97:90] voltage,
                                       // [103:98] zero
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       out_valid_r;
  result_t    out_res_r;
  logic       advance;
  logic       res_valid;
  result_t    res;

  // Move the held byte on whenever the output register is free or draining
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  mfd_frame_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_valid_r && advance),
    .rx_byte   (in_byte_r),
    .frame_end (in_last_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end
  end

  // Hold the result while the receiver stalls
  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W - RES_W)'(0), out_res_r};

endmodule

### design/mfd_checker.sv
module mfd_checker
  import mfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tready,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // With the output empty the decoder must take bytes
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // A failed frame reports no fields
  a_fields_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_OK |-> out_tdata[RES_W-1:2] == '0)
    else $error("fields set on failed frame");

  // Padding above the result stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_W-1:RES_W] == '0)
    else $error("nonzero padding");

  // No result in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result after reset");

endmodule

bind motor_feedback_frame_decoder mfd_checker u_mfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
